[hw/rtl/cle_pkg.sv]
// cle_pkg: shared types and key codes for the cursor line editor
// no dependencies; used by cle_cell and cursor_line_editor
package cle_pkg;

  localparam logic [7:0] KEY_LEFT  = 8'h3C;
  localparam logic [7:0] KEY_RIGHT = 8'h3E;
  localparam logic [7:0] KEY_BACK  = 8'h2D;

  typedef struct packed {
    logic [7:0] key;
    logic       end_of_line;
  } key_item_t;

  typedef struct packed {
    logic [7:0] character;
    logic       has_character;
    logic       last;
    logic       overflowed;
  } line_item_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_DELETE,
    OP_SHIFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t   op;
    logic [7:0] key;
  } cell_ctrl_t;

endpackage

[hw/rtl/cle_cell.sv]
// cle_cell: one character slot of the line, linked to its two neighbors
// depends on cle_pkg for the cell control struct
module cle_cell #(
  parameter int IDX = 0,
  parameter int PW  = 7
) (
  input  logic                clk,
  input  cle_pkg::cell_ctrl_t ctrl,
  input  logic [PW-1:0]       pos,
  input  logic [7:0]          from_left,
  input  logic [7:0]          from_right,
  output logic [7:0]          data
);

  localparam logic [PW-1:0] MY_IDX  = PW'(IDX);
  localparam logic [PW-1:0] NXT_IDX = PW'(IDX + 1);

  logic [7:0] data_next;

  always_comb begin
    data_next = data;
    case (ctrl.op)
      cle_pkg::OP_INSERT: begin
        if (MY_IDX > pos) begin
          data_next = from_left;
        end else if (MY_IDX == pos) begin
          data_next = ctrl.key;
        end
      end
      cle_pkg::OP_DELETE: begin
        if (NXT_IDX >= pos) begin
          data_next = from_right;
        end
      end
      cle_pkg::OP_SHIFT: begin
        data_next = from_right;
      end
      default: begin
        data_next = data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

[hw/rtl/cursor_line_editor.sv]
// cursor_line_editor: keystroke line editor built as a row of character cells
// depends on cle_pkg and cle_cell
//
// The line lives in a row of LINE_CAPACITY cells, one character each; an insert
// or backspace moves the characters right of the cursor one cell, all at once,
// and cursor moves only change a pointer. Key items without end_of_line are
// taken back to back. An item with end_of_line is applied like any other key
// and then drains the line through the output register at one character a
// cycle, while the output side does not stall, by shifting the whole row
// toward cell 0; no further key is taken until the drain is done. An empty
// line gives a single marker item with has_character low. The overflow flag
// reports any dropped insert of that line and is repeated on each of its items.
module cursor_line_editor #(
  parameter int LINE_CAPACITY = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  key_valid,
  output logic                  key_ready,
  input  cle_pkg::key_item_t    key_item,
  output logic                  line_valid,
  input  logic                  line_ready,
  output cle_pkg::line_item_t   line_item
);

  localparam int PW = $clog2(LINE_CAPACITY + 1);
  localparam logic [PW-1:0] CAP = PW'(LINE_CAPACITY);

  typedef enum logic {
    S_EDIT,
    S_FLUSH
  } state_t;

  state_t              state, state_next;
  logic [PW-1:0]       cursor, cursor_next;
  logic [PW-1:0]       len, len_next;
  logic [PW-1:0]       rem, rem_next;
  logic                ovf, ovf_next;
  logic                key_take;
  logic                out_load;
  logic                flush_last;
  cle_pkg::cell_ctrl_t ctrl;
  logic [7:0]          cell_data [LINE_CAPACITY];

  assign key_ready  = (state == S_EDIT);
  assign key_take   = key_valid && key_ready;
  assign out_load   = (state == S_FLUSH) && (!line_valid || line_ready);
  assign flush_last = (rem == '0) || (rem == PW'(1));

  always_comb begin
    state_next  = state;
    cursor_next = cursor;
    len_next    = len;
    rem_next    = rem;
    ovf_next    = ovf;
    ctrl.op     = cle_pkg::OP_HOLD;
    ctrl.key    = key_item.key;
    if (key_take) begin
      case (key_item.key)
        cle_pkg::KEY_LEFT: begin
          if (cursor != '0) begin
            cursor_next = cursor - PW'(1);
          end
        end
        cle_pkg::KEY_RIGHT: begin
          if (cursor != len) begin
            cursor_next = cursor + PW'(1);
          end
        end
        cle_pkg::KEY_BACK: begin
          if (cursor != '0) begin
            ctrl.op     = cle_pkg::OP_DELETE;
            cursor_next = cursor - PW'(1);
            len_next    = len - PW'(1);
          end
        end
        default: begin
          if (len == CAP) begin
            ovf_next = 1'b1;
          end else begin
            ctrl.op     = cle_pkg::OP_INSERT;
            cursor_next = cursor + PW'(1);
            len_next    = len + PW'(1);
          end
        end
      endcase
      if (key_item.end_of_line) begin
        state_next = S_FLUSH;
        rem_next   = len_next;
      end
    end else if (out_load) begin
      ctrl.op = cle_pkg::OP_SHIFT;
      if (flush_last) begin
        state_next  = S_EDIT;
        cursor_next = '0;
        len_next    = '0;
        ovf_next    = 1'b0;
      end else begin
        rem_next = rem - PW'(1);
      end
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < LINE_CAPACITY; gi++) begin : g_cell
      logic [7:0] left_in;
      logic [7:0] right_in;
      if (gi == 0) begin : g_first
        assign left_in = '0;
      end else begin : g_mid_l
        assign left_in = cell_data[gi-1];
      end
      if (gi == LINE_CAPACITY - 1) begin : g_end
        assign right_in = '0;
      end else begin : g_mid_r
        assign right_in = cell_data[gi+1];
      end
      cle_cell #(
        .IDX (gi),
        .PW  (PW)
      ) u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .pos        (cursor),
        .from_left  (left_in),
        .from_right (right_in),
        .data       (cell_data[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_EDIT;
      cursor     <= '0;
      len        <= '0;
      rem        <= '0;
      ovf        <= 1'b0;
      line_valid <= 1'b0;
    end else begin
      state  <= state_next;
      cursor <= cursor_next;
      len    <= len_next;
      rem    <= rem_next;
      ovf    <= ovf_next;
      if (out_load) begin
        line_valid <= 1'b1;
      end else if (line_ready) begin
        line_valid <= 1'b0;
      end
    end
    if (out_load) begin
      line_item.character     <= (rem == '0) ? 8'h00 : cell_data[0];
      line_item.has_character <= (rem != '0);
      line_item.last          <= flush_last;
      line_item.overflowed    <= ovf;
    end
  end

  a_cursor_in_line: assert property (@(posedge clk) disable iff (rst)
    cursor <= len)
    else $error("cursor beyond end of line");

  a_len_in_range: assert property (@(posedge clk) disable iff (rst)
    len <= CAP)
    else $error("line length above capacity");

  a_eol_flushes: assert property (@(posedge clk) disable iff (rst)
    key_take && key_item.end_of_line |=> state == S_FLUSH)
    else $error("end of line item did not start a flush");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    out_load && flush_last |=> (len == '0) && (cursor == '0) && !ovf)
    else $error("line not cleared after final item");

  a_marker_is_last: assert property (@(posedge clk) disable iff (rst)
    line_valid && !line_item.has_character |-> line_item.last)
    else $error("empty line marker not flagged last");

endmodule

[bench/cursor_line_editor_checker.sv]
`timescale 1ns / 100ps
// cursor_line_editor_checker: watches both channels of the line editor, keeps its own
// two-stack copy of the line and compares every line item with the predicted one
// depends on cle_pkg
module cursor_line_editor_checker #(
  parameter int LINE_CAPACITY = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                key_valid,
  input  logic                key_ready,
  input  cle_pkg::key_item_t  key_item,
  input  logic                line_valid,
  input  logic                line_ready,
  input  cle_pkg::line_item_t line_item,
  output int                  fail_count,
  output int                  waiting,
  output int                  checked
);

  logic [7:0]          left_chars [LINE_CAPACITY];
  logic [7:0]          right_chars[LINE_CAPACITY];
  int unsigned         left_n;
  int unsigned         right_n;
  logic                dropped;
  cle_pkg::line_item_t pending_chars[$];
  cle_pkg::line_item_t want;

  task automatic apply_keystroke(cle_pkg::key_item_t it);
    int unsigned total;
    int unsigned n;
    case (it.key)
      cle_pkg::KEY_LEFT: begin
        if (left_n > 0 && right_n < LINE_CAPACITY) begin
          left_n--;
          right_chars[right_n] = left_chars[left_n];
          right_n++;
        end
      end
      cle_pkg::KEY_RIGHT: begin
        if (right_n > 0 && left_n < LINE_CAPACITY) begin
          right_n--;
          left_chars[left_n] = right_chars[right_n];
          left_n++;
        end
      end
      cle_pkg::KEY_BACK: begin
        if (left_n > 0) left_n--;
      end
      default: begin
        if (left_n + right_n >= LINE_CAPACITY) begin
          dropped = 1'b1;
        end else begin
          left_chars[left_n] = it.key;
          left_n++;
        end
      end
    endcase
    if (it.end_of_line) begin
      total = left_n + right_n;
      n = 0;
      if (total == 0) begin
        pending_chars.push_back(cle_pkg::line_item_t'{character: 8'h00, has_character: 1'b0,
                                                      last: 1'b1, overflowed: dropped});
      end else begin
        for (int unsigned i = 0; i < left_n; i++) begin
          pending_chars.push_back(cle_pkg::line_item_t'{character: left_chars[i],
                                                        has_character: 1'b1,
                                                        last: (n + 1 == total),
                                                        overflowed: dropped});
          n++;
        end
        for (int unsigned i = right_n; i > 0; i--) begin
          pending_chars.push_back(cle_pkg::line_item_t'{character: right_chars[i - 1],
                                                        has_character: 1'b1,
                                                        last: (n + 1 == total),
                                                        overflowed: dropped});
          n++;
        end
      end
      left_n = 0;
      right_n = 0;
      dropped = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      left_n = 0;
      right_n = 0;
      dropped = 1'b0;
      pending_chars.delete();
    end else begin
      if (line_valid && line_ready) begin
        checked++;
        if (pending_chars.size() == 0) begin
          $error("unexpected line item: character %0h has_character %0b last %0b",
                 line_item.character, line_item.has_character, line_item.last);
          fail_count++;
        end else begin
          want = pending_chars.pop_front();
          if (line_item.character !== want.character) begin
            $error("character: expected %0h, got %0h", want.character, line_item.character);
            fail_count++;
          end
          if (line_item.has_character !== want.has_character) begin
            $error("has_character: expected %0b, got %0b", want.has_character,
                   line_item.has_character);
            fail_count++;
          end
          if (line_item.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, line_item.last);
            fail_count++;
          end
          if (line_item.overflowed !== want.overflowed) begin
            $error("overflowed: expected %0b, got %0b", want.overflowed, line_item.overflowed);
            fail_count++;
          end
        end
      end
      if (key_valid && key_ready) apply_keystroke(key_item);
    end
    waiting = pending_chars.size();
  end

endmodule

[bench/cursor_line_editor_test.sv]
`timescale 1ns / 100ps
// cursor_line_editor_test: drives keystroke items into the line editor with random
// gaps and output stalls, then judges by the checker's failure and waiting counts
// depends on cle_pkg, cursor_line_editor and cursor_line_editor_checker
module cursor_line_editor_test;

  localparam int LINE_CAPACITY = 64;
  localparam int KEY_ITEMS = 230;

  logic                clk;
  logic                rst = 1'b1;
  logic                key_valid = 1'b0;
  logic                key_ready;
  cle_pkg::key_item_t  key_item = '0;
  logic                line_valid;
  logic                line_ready = 1'b0;
  cle_pkg::line_item_t line_item;

  int fail_count;
  int waiting;
  int checked;
  int sent = 0;
  int stall_left = 0;
  bit steady = 1'b0;

  cursor_line_editor #(.LINE_CAPACITY(LINE_CAPACITY)) DUT (
    .clk(clk),
    .rst(rst),
    .key_valid(key_valid),
    .key_ready(key_ready),
    .key_item(key_item),
    .line_valid(line_valid),
    .line_ready(line_ready),
    .line_item(line_item)
  );

  cursor_line_editor_checker #(.LINE_CAPACITY(LINE_CAPACITY)) u_checker (
    .clk(clk),
    .rst(rst),
    .key_valid(key_valid),
    .key_ready(key_ready),
    .key_item(key_item),
    .line_valid(line_valid),
    .line_ready(line_ready),
    .line_item(line_item),
    .fail_count(fail_count),
    .waiting(waiting),
    .checked(checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // output side stalls
  always @(negedge clk) begin
    if (stall_left == 0 && !steady && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    if (stall_left > 0) begin
      line_ready <= 1'b0;
      stall_left--;
    end else begin
      line_ready <= 1'b1;
    end
  end

  task automatic send_key(logic [7:0] k, logic eol);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      key_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    key_item <= '{key: k, end_of_line: eol};
    key_valid <= 1'b1;
    @(posedge clk);
    while (!key_ready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic drain_lines();
    key_valid <= 1'b0;
    while (waiting != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_key(int insert_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < insert_pct) return 8'($urandom_range(0, 255));
    r = $urandom_range(0, 2);
    if (r == 0) return cle_pkg::KEY_LEFT;
    if (r == 1) return cle_pkg::KEY_RIGHT;
    return cle_pkg::KEY_BACK;
  endfunction

  task automatic type_line(int len, int insert_pct);
    for (int i = 0; i < len; i++) send_key(pick_key(insert_pct), i == len - 1);
  endtask

  initial begin
    int r;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty lines, cursor moves and backspace at both ends
    send_key(cle_pkg::KEY_LEFT, 1'b1);
    send_key(cle_pkg::KEY_BACK, 1'b1);
    send_key(cle_pkg::KEY_RIGHT, 1'b0);
    send_key(8'h00, 1'b0);
    send_key(8'hFF, 1'b0);
    send_key(8'h61, 1'b0);
    send_key(cle_pkg::KEY_LEFT, 1'b0);
    send_key(cle_pkg::KEY_LEFT, 1'b0);
    send_key(8'h62, 1'b0);
    send_key(cle_pkg::KEY_RIGHT, 1'b0);
    send_key(cle_pkg::KEY_RIGHT, 1'b0);
    send_key(cle_pkg::KEY_RIGHT, 1'b0);
    send_key(cle_pkg::KEY_BACK, 1'b0);
    repeat (5) send_key(cle_pkg::KEY_LEFT, 1'b0);
    send_key(cle_pkg::KEY_BACK, 1'b0);
    send_key(8'h7F, 1'b1);
    send_key(8'h80, 1'b1);
    send_key(8'h71, 1'b0);
    send_key(cle_pkg::KEY_BACK, 1'b1);

    drain_lines();

    // full buffer: dropped inserts, then moves and a freed slot
    steady = 1'b1;
    repeat (LINE_CAPACITY + 2) send_key(8'h41 + 8'($urandom_range(0, 25)), 1'b0);
    steady = 1'b0;
    send_key(cle_pkg::KEY_LEFT, 1'b0);
    send_key(cle_pkg::KEY_LEFT, 1'b0);
    send_key(cle_pkg::KEY_BACK, 1'b0);
    send_key(8'h5A, 1'b0);
    send_key(8'h5B, 1'b1);

    while (sent < KEY_ITEMS) begin
      steady = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      if (r < 70) begin
        type_line($urandom_range(1, 8), 55);
      end else if (r < 96) begin
        type_line($urandom_range(9, 24), 55);
      end else begin
        type_line($urandom_range(LINE_CAPACITY - 4, LINE_CAPACITY + 8), 92);
      end
      if ($urandom_range(0, 9) == 0) drain_lines();
    end
    steady = 1'b0;

    key_valid <= 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (4 * LINE_CAPACITY) @(negedge clk);

    if (waiting != 0) $error("%0d line items never arrived", waiting);
    $display("%0d key items sent, %0d line items checked", sent, checked);
    $display("covered empty lines, edits at both ends and a full buffer with dropped inserts");
    if (fail_count == 0 && waiting == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/cle_pkg.sv
hw/rtl/cle_cell.sv
hw/rtl/cursor_line_editor.sv
bench/cursor_line_editor_checker.sv
bench/cursor_line_editor_test.sv
